[rtl/sio_cfg_pkg.sv]
package sio_cfg_pkg;

  localparam int REG_COUNT  = 256;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int HOLD_SLOTS = 16;

  // Access opcodes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Port addresses of the two key windows.
  localparam logic [15:0] PORT_LO_KEY = 16'h0250;
  localparam logic [15:0] PORT_LO_IDX = 16'h0251;
  localparam logic [15:0] PORT_LO_DAT = 16'h0252;
  localparam logic [15:0] PORT_HI_IDX = 16'h03F0;
  localparam logic [15:0] PORT_HI_DAT = 16'h03F1;

  localparam logic [7:0] EXIT_INDEX    = 8'hAA;
  localparam logic [7:0] PROTECT_LIMIT = 8'h18;
  localparam logic [7:0] KEY_HI_BASE   = 8'h86;
  localparam logic [7:0] KEY_LO_BASE   = 8'h88;
  localparam logic [7:0] KEY_RESET     = 8'h87;
  localparam logic [7:0] BYTE_ONES     = 8'hFF;

  localparam logic [9:0] SERIAL_A_FALLBACK = 10'h3F8;
  localparam logic [9:0] SERIAL_B_FALLBACK = 10'h2F8;
  localparam logic [9:0] SERIAL_BASE_MIN   = 10'h100;

  // Register indexes that are held in flip-flops.
  localparam logic [7:0] REG_SERIAL_DIS = 8'h04;
  localparam logic [7:0] REG_FDC_DIS    = 8'h06;
  localparam logic [7:0] REG_PROTECT    = 8'h09;
  localparam logic [7:0] REG_KEY_SEL    = 8'h0C;
  localparam logic [7:0] REG_WINDOW     = 8'h16;
  localparam logic [7:0] REG_DFLT_FIRST = 8'h1E;
  localparam logic [7:0] REG_FDC_BASE   = 8'h20;
  localparam logic [7:0] REG_DFLT_LAST  = 8'h29;

  // Slot numbers of the flip-flop registers.
  localparam logic [3:0] SLOT_04 = 4'd0;
  localparam logic [3:0] SLOT_06 = 4'd1;
  localparam logic [3:0] SLOT_09 = 4'd2;
  localparam logic [3:0] SLOT_0C = 4'd3;
  localparam logic [3:0] SLOT_16 = 4'd4;
  localparam logic [3:0] SLOT_1E = 4'd5;
  localparam logic [3:0] SLOT_20 = 4'd6;
  localparam logic [3:0] SLOT_24 = 4'd10;
  localparam logic [3:0] SLOT_25 = 4'd11;
  localparam logic [3:0] SLOT_28 = 4'd14;
  localparam logic [3:0] SLOT_29 = 4'd15;

  // Power-on values of the slots; slots 1E and 20..29 are also the reload defaults.
  localparam logic [7:0] HOLD_RESET [HOLD_SLOTS] = '{
    8'h00, 8'h00, 8'h0A, 8'h28, 8'h07, 8'h81, 8'hFC, 8'h7C,
    8'hFD, 8'hDE, 8'hFE, 8'hBE, 8'h23, 8'h65, 8'h43, 8'h62
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] num;
  } slot_t;

  typedef struct packed {
    logic       enabled;
    logic [9:0] base;
    logic [3:0] irq;
  } serial_t;

  function automatic slot_t hold_slot(input logic [7:0] idx);
    slot_t s;
    s.hit = 1'b1;
    s.num = SLOT_04;
    case (idx)
      REG_SERIAL_DIS: s.num = SLOT_04;
      REG_FDC_DIS:    s.num = SLOT_06;
      REG_PROTECT:    s.num = SLOT_09;
      REG_KEY_SEL:    s.num = SLOT_0C;
      REG_WINDOW:     s.num = SLOT_16;
      REG_DFLT_FIRST: s.num = SLOT_1E;
      default: begin
        if (idx inside {[REG_FDC_BASE:REG_DFLT_LAST]}) begin
          s.num = SLOT_20 + idx[3:0];
        end else begin
          s.hit = 1'b0;
        end
      end
    endcase
    return s;
  endfunction

  // Power-on values of the registers that live in the RAM.
  function automatic logic [7:0] ram_default(input logic [7:0] idx);
    logic [7:0] d;
    case (idx)
      8'h03:   d = 8'h30;
      8'h07:   d = 8'hF5;
      8'h0A:   d = 8'h1F;
      8'h0D:   d = 8'hA3;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] irq_of(input logic [3:0] code);
    logic [3:0] q;
    case (code)
      4'd1:    q = 4'd5;
      4'd2:    q = 4'd2;
      4'd3:    q = 4'd3;
      4'd4:    q = 4'd4;
      4'd5:    q = 4'd7;
      4'd6:    q = 4'd6;
      4'd7:    q = 4'd9;
      4'd8:    q = 4'd10;
      default: q = 4'd0;
    endcase
    return q;
  endfunction

endpackage

[rtl/sio_cfg_req_if.sv]
interface sio_cfg_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] io_address;
  logic [7:0]  write_data;

  modport source (output valid, opcode, io_address, write_data, input ready);
  modport sink (input valid, opcode, io_address, write_data, output ready);
endinterface

[rtl/sio_cfg_rsp_if.sv]
interface sio_cfg_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       floppy_forward;
  logic       config_mode;
  logic       serial_a_enabled;
  logic [9:0] serial_a_base;
  logic [3:0] serial_a_irq;
  logic       serial_b_enabled;
  logic [9:0] serial_b_base;
  logic [3:0] serial_b_irq;

  modport source (
    output valid, read_data, floppy_forward, config_mode,
           serial_a_enabled, serial_a_base, serial_a_irq,
           serial_b_enabled, serial_b_base, serial_b_irq,
    input ready
  );
  modport sink (
    input valid, read_data, floppy_forward, config_mode,
          serial_a_enabled, serial_a_base, serial_a_irq,
          serial_b_enabled, serial_b_base, serial_b_irq,
    output ready
  );
endinterface

[rtl/sio_cfg_ram.sv]
module sio_cfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sio_cfg_serial_dec.sv]
module sio_cfg_serial_dec
  import sio_cfg_pkg::*;
(
  input  logic       disable_bit,
  input  logic [7:0] base_reg,
  input  logic [3:0] irq_code,
  input  logic [9:0] fallback_base,
  output serial_t    port
);

  logic [9:0] base;
  logic [3:0] irq;

  always_comb begin
    base = {base_reg[7:1], 3'b000};
    if (base < SERIAL_BASE_MIN) begin
      base = fallback_base;
    end
    irq = irq_of(irq_code);
    port = '0;
    if (!disable_bit && base_reg[7:6] != 2'b00 && irq != 4'd0) begin
      port.enabled = 1'b1;
      port.base    = base;
      port.irq     = irq;
    end
  end

endmodule

[rtl/superio_config_port_unlock.sv]
// Super I/O configuration front end with key-unlocked configuration mode.
// The req channel carries one I/O access per word: opcode (0 read, 1 write),
// a 16-bit port address and the write byte. The rsp channel returns one word
// per access with the read byte, the floppy pass-through flag, the
// configuration mode flag and the decoded state of both serial ports as it
// stands after the access.
// An access accepted in one cycle shows on rsp in the next. One access is
// taken per cycle while the receiver takes each word; the decode and the
// register file update sit between the accepted word and the result register.
// The register file is a 256-entry RAM with registered read, addressed by the
// next value of the index, so the byte at the index is ready when the next
// access arrives; a bypass register covers a write to that same entry.
// Registers that drive decode or are bulk reloaded are kept in flip-flops.
// Reset is synchronous: the index, key state, window and flip-flop registers
// take their power-on values at once, and per-entry valid bits make unwritten
// RAM entries read as their power-on value, so no clearing pass is needed.
// When the receiver stalls, the result word holds and req.ready stays low
// until the word is taken; a new access is accepted in the same cycle as the
// held word leaves.
module superio_config_port_unlock
  import sio_cfg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sio_cfg_req_if.sink          req,
  sio_cfg_rsp_if.source        rsp
);

  // Configuration state.
  logic [7:0]  idx, idx_next;
  logic        unlocked, unlocked_next;
  logic        write_protect, write_protect_next;
  logic        first_key_seen, first_key_seen_next;
  logic        high_window, high_window_next;
  logic [7:0]  unlock_key, unlock_key_next;
  logic [7:0]  hold [HOLD_SLOTS];
  logic [7:0]  hold_next [HOLD_SLOTS];

  // RAM side of the register file.
  logic [REG_COUNT-1:0] valid_bits;
  logic                 ram_we;
  logic [7:0]           ram_rdata;
  logic                 bypass_hit;
  logic [7:0]           bypass_data;

  logic        fire;
  slot_t       cur_slot;
  logic [7:0]  mem_val;
  logic [7:0]  cur_val;
  logic [7:0]  data_read_val;
  logic [7:0]  result_data;
  logic        result_fwd;
  serial_t     serial_a, serial_b;

  assign fire      = req.valid && req.ready;
  assign req.ready = !rsp.valid || rsp.ready;

  // Byte currently addressed by the index, wherever it lives.
  always_comb begin
    cur_slot = hold_slot(idx);
    if (bypass_hit) begin
      mem_val = bypass_data;
    end else if (valid_bits[idx]) begin
      mem_val = ram_rdata;
    end else begin
      mem_val = ram_default(idx);
    end
    cur_val = cur_slot.hit ? hold[cur_slot.num] : mem_val;
    data_read_val = (!write_protect || idx >= PROTECT_LIMIT) ? cur_val : BYTE_ONES;
  end

  // One access: port decode, key sequence, index and register writes.
  always_comb begin
    logic       is_write;
    logic [15:0] port;
    logic [7:0] v;
    logic       fdc_port;
    logic       fdc_on;
    logic       do_key;
    logic       do_index;
    logic       do_reg;
    logic       reload;
    logic [7:0] changed;
    logic       sel;

    is_write = req.opcode == OP_WRITE;
    port     = req.io_address;
    v        = req.write_data;
    fdc_port = port == PORT_HI_IDX || port == PORT_HI_DAT;
    fdc_on   = !hold[SLOT_06][3] && hold[SLOT_20][7:6] != 2'b00 &&
               hold[SLOT_20][7:2] == 6'h3F;
    do_key   = 1'b0;
    do_index = 1'b0;
    do_reg   = 1'b0;
    reload   = 1'b0;
    changed  = cur_val ^ v;
    sel      = 1'b0;

    idx_next            = idx;
    unlocked_next       = unlocked;
    write_protect_next  = write_protect;
    first_key_seen_next = first_key_seen;
    high_window_next    = high_window;
    unlock_key_next     = unlock_key;
    hold_next           = hold;
    ram_we              = 1'b0;
    result_data         = BYTE_ONES;
    result_fwd          = 1'b0;

    if (fire) begin
      if (!high_window) begin
        if (is_write) begin
          if (port == PORT_LO_KEY) begin
            do_key = 1'b1;
          end else if (port == PORT_LO_IDX) begin
            do_index = unlocked;
          end else if (port == PORT_LO_DAT) begin
            do_reg = unlocked;
          end else if (fdc_port && fdc_on) begin
            result_fwd = 1'b1;
          end
        end else begin
          if (unlocked && port == PORT_LO_IDX) begin
            result_data = idx;
          end else if (unlocked && port == PORT_LO_DAT) begin
            result_data = data_read_val;
          end else if (fdc_port && fdc_on) begin
            result_fwd = 1'b1;
          end
        end
      end else if (fdc_port) begin
        if (is_write) begin
          if (unlocked) begin
            do_index = port == PORT_HI_IDX;
            do_reg   = port != PORT_HI_IDX;
          end else if (port == PORT_HI_IDX && v == unlock_key) begin
            do_key = 1'b1;
          end else begin
            if (port == PORT_HI_IDX) begin
              first_key_seen_next = 1'b0;
            end
            result_fwd = fdc_on;
          end
        end else begin
          if (unlocked) begin
            result_data = (port == PORT_HI_IDX) ? idx : data_read_val;
          end else begin
            result_fwd = fdc_on;
          end
        end
      end

      if (is_write) begin
        result_data = BYTE_ONES;
      end

      // Unlock key sequence: once in the low window, twice in the high one.
      if (do_key) begin
        if (v != unlock_key) begin
          first_key_seen_next = 1'b0;
          unlocked_next       = 1'b0;
        end else if (!high_window || first_key_seen) begin
          unlocked_next       = 1'b1;
          first_key_seen_next = 1'b0;
        end else begin
          first_key_seen_next = 1'b1;
        end
      end

      if (do_index) begin
        idx_next = v;
        if (v == EXIT_INDEX) begin
          unlocked_next = 1'b0;
        end
      end

      // Register write with its side effects; protected registers drop it.
      if (do_reg && !(write_protect && idx < PROTECT_LIMIT)) begin
        if (cur_slot.hit) begin
          hold_next[cur_slot.num] = v;
        end else begin
          ram_we = 1'b1;
        end
        if (idx == REG_PROTECT && changed[6]) begin
          write_protect_next = v[6];
        end else if (idx == REG_KEY_SEL && changed[5]) begin
          reload = 1'b1;
        end else if (idx == REG_WINDOW) begin
          if (changed[1]) begin
            for (int s = SLOT_1E; s <= SLOT_29; s++) begin
              hold_next[s] = v[1] ? HOLD_RESET[s] : 8'h00;
            end
          end
          reload = changed[0];
        end
      end

      // The key and window follow the register values written just now.
      if (reload) begin
        sel                 = hold_next[SLOT_0C][5];
        high_window_next    = hold_next[SLOT_16][0];
        unlock_key_next     = (high_window_next ? KEY_HI_BASE : KEY_LO_BASE) |
                              {7'd0, sel};
        first_key_seen_next = 1'b0;
      end
    end
  end

  sio_cfg_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[REG_AW-1:0]),
    .wdata (req.write_data),
    .raddr (idx_next[REG_AW-1:0]),
    .rdata (ram_rdata)
  );

  // The serial ports are decoded from the state after the access.
  sio_cfg_serial_dec u_serial_a (
    .disable_bit   (hold_next[SLOT_04][5]),
    .base_reg      (hold_next[SLOT_24]),
    .irq_code      (hold_next[SLOT_28][7:4]),
    .fallback_base (SERIAL_A_FALLBACK),
    .port          (serial_a)
  );

  sio_cfg_serial_dec u_serial_b (
    .disable_bit   (hold_next[SLOT_04][4]),
    .base_reg      (hold_next[SLOT_25]),
    .irq_code      (hold_next[SLOT_28][3:0]),
    .fallback_base (SERIAL_B_FALLBACK),
    .port          (serial_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      unlocked       <= 1'b0;
      write_protect  <= 1'b0;
      first_key_seen <= 1'b0;
      high_window    <= 1'b1;
      unlock_key     <= KEY_RESET;
      hold           <= HOLD_RESET;
      valid_bits     <= '0;
      bypass_hit     <= 1'b0;
      rsp.valid      <= 1'b0;
    end else begin
      idx            <= idx_next;
      unlocked       <= unlocked_next;
      write_protect  <= write_protect_next;
      first_key_seen <= first_key_seen_next;
      high_window    <= high_window_next;
      unlock_key     <= unlock_key_next;
      hold           <= hold_next;
      bypass_hit     <= ram_we;
      if (ram_we) begin
        valid_bits[idx] <= 1'b1;
      end
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bypass_data <= req.write_data;
    if (fire) begin
      rsp.read_data        <= result_data;
      rsp.floppy_forward   <= result_fwd;
      rsp.config_mode      <= unlocked_next;
      rsp.serial_a_enabled <= serial_a.enabled;
      rsp.serial_a_base    <= serial_a.base;
      rsp.serial_a_irq     <= serial_a.irq;
      rsp.serial_b_enabled <= serial_b.enabled;
      rsp.serial_b_base    <= serial_b.base;
      rsp.serial_b_irq     <= serial_b.irq;
    end
  end

endmodule

[rtl/sio_cfg_checker.sv]
module sio_cfg_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_opcode,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_data,
  input logic       rsp_a_enabled,
  input logic [9:0] rsp_a_base,
  input logic [3:0] rsp_a_irq
);

  // The block never refuses an access while its result register is free.
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("request refused while result register is free");

  // Every accepted access yields a result word in the next cycle.
  a_one_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted access gave no result word");

  // A stalled result word holds its data.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)))
    else $error("stalled result word changed");

  // Writes always return all ones as read data.
  a_write_reads_ones: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_opcode) |=> (rsp_read_data == 8'hFF))
    else $error("write returned read data other than all ones");

  // A disabled serial port reports no base and no interrupt line.
  a_serial_a_off: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_a_enabled) |-> (rsp_a_base == 10'd0 && rsp_a_irq == 4'd0))
    else $error("disabled serial port reports a base or an interrupt line");

endmodule

bind superio_config_port_unlock sio_cfg_checker u_sio_cfg_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_opcode    (req.opcode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data),
  .rsp_a_enabled (rsp.serial_a_enabled),
  .rsp_a_base    (rsp.serial_a_base),
  .rsp_a_irq     (rsp.serial_a_irq)
);
